// ===== rtl/diatonic_chord_interval_builder_macros.svh =====
// assertion macros for the diatonic chord interval builder
// no dependencies; included by dcib_back, the module that checks its own logic
`ifndef DIATONIC_CHORD_INTERVAL_BUILDER_MACROS_SVH
`define DIATONIC_CHORD_INTERVAL_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define DCIB_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("dcib check failed");
`define DCIB_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("dcib check failed");
`else
`define DCIB_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons)
`define DCIB_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons)
`endif
`endif

// ===== rtl/dcib_pkg.sv =====
// shared types, constants and scale tables of the diatonic chord interval builder
// no dependencies
package dcib_pkg;

	localparam int MAX_NOTES = 7;
	localparam int SLOTS     = 7;
	localparam int NOTE_W    = 5;
	localparam int IDX_W     = 3;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_NOTES - 1);
	localparam logic [3:0] OCTAVE = 4'd12;

	// slot order of a chord
	localparam int SLOT_ROOT    = 0;
	localparam int SLOT_THIRD   = 1;
	localparam int SLOT_FIFTH   = 2;
	localparam int SLOT_SEVENTH = 3;
	localparam int SLOT_NINTH   = 4;
	localparam int SLOT_ELEVEN  = 5;
	localparam int SLOT_THIRTN  = 6;

	// scale steps above the chord degree
	localparam logic [4:0] STEPS_THIRD   = 5'd2;
	localparam logic [4:0] STEPS_FIFTH   = 5'd4;
	localparam logic [4:0] STEPS_SEVENTH = 5'd6;
	localparam logic [4:0] STEPS_NINTH   = 5'd8;
	localparam logic [4:0] STEPS_ELEVEN  = 5'd10;
	localparam logic [4:0] STEPS_THIRTN  = 5'd12;

	typedef enum logic [2:0] {
		CFG_SCALE_MODE     = 3'd0,
		CFG_TONIC_CLASS    = 3'd1,
		CFG_TRIAD_FORM     = 3'd2,
		CFG_SEVENTH_FORM   = 3'd3,
		CFG_ADD_SEVENTH    = 3'd4,
		CFG_ADD_NINTH      = 3'd5,
		CFG_ADD_ELEVENTH   = 3'd6,
		CFG_ADD_THIRTEENTH = 3'd7
	} cfg_idx_t;

	localparam logic [2:0] MODE_WRAP       = 3'd7;
	localparam logic [2:0] TRIAD_DIATONIC  = 3'd0;
	localparam logic [2:0] TRIAD_ROOT_ONLY = 3'd7;

	typedef enum logic [1:0] {
		SEV_NONE  = 2'd0,
		SEV_SIXTH = 2'd1,
		SEV_MIN7  = 2'd2,
		SEV_MAJ7  = 2'd3
	} sev_form_t;

	localparam logic [4:0] SIXTH_SEMIS = 5'd9;
	localparam logic [4:0] MIN7_SEMIS  = 5'd10;
	localparam logic [4:0] MAJ7_SEMIS  = 5'd11;

	localparam logic [3:0] MODE_TAB [0:6][0:6] = '{
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10}
	};

	// third and fifth of the fixed triad forms, diatonic entry unused
	localparam logic [3:0] TRIAD_TAB [0:6][0:1] = '{
		'{4'd0, 4'd0}, '{4'd4, 4'd7}, '{4'd3, 4'd7}, '{4'd3, 4'd6},
		'{4'd4, 4'd8}, '{4'd2, 4'd7}, '{4'd5, 4'd7}
	};

	typedef struct packed {
		logic [2:0] scale_mode;
		logic [3:0] tonic_class;
		logic [2:0] triad_form;
		logic [1:0] seventh_form;
		logic       add_seventh;
		logic       add_ninth;
		logic       add_eleventh;
		logic       add_thirteenth;
	} cfg_t;

	// one classified key: candidate notes and which of them sound
	typedef struct packed {
		logic [SLOTS-1:0][NOTE_W-1:0] notes;
		logic [SLOTS-1:0]             mask;
		logic                         key_valid;
	} entry_t;

	// semitones from degree deg up by steps scale steps
	function automatic logic [4:0] step_up(input logic [2:0] mode, input logic [2:0] deg,
			input logic [4:0] steps);
		logic [4:0] t;
		logic [4:0] oct;
		t   = 5'(deg) + steps;
		oct = 5'd0;
		if (t >= 5'd14) begin
			t   = t - 5'd14;
			oct = 5'd24;
		end else if (t >= 5'd7) begin
			t   = t - 5'd7;
			oct = 5'd12;
		end
		return 5'(MODE_TAB[mode][t[2:0]]) + oct - 5'(MODE_TAB[mode][deg]);
	endfunction

endpackage

// ===== rtl/dcib_front.sv =====
// front: accepts a key beat, registers it and classifies it into a chord entry
// depends on dcib_pkg
module dcib_front (
	input  logic            clk,
	input  logic            arst_n,
	input  dcib_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [3:0]      key_class,
	output logic            push,
	input  logic            q_ready,
	output dcib_pkg::entry_t entry
);
	import dcib_pkg::*;

	logic       valid_s1;
	logic [3:0] key_s1;

	logic [2:0] mode;
	logic [3:0] tonic;
	logic [4:0] diff;
	logic [3:0] rel;
	logic [2:0] deg;
	logic       kv;

	assign in_ready = !valid_s1 || q_ready;
	assign push     = valid_s1 && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1 <= key_class;
		end
	end

	always_comb begin
		mode  = (cfg.scale_mode == MODE_WRAP) ? 3'd0 : cfg.scale_mode;
		tonic = (cfg.tonic_class >= OCTAVE) ? cfg.tonic_class - OCTAVE : cfg.tonic_class;
		kv    = key_s1 < OCTAVE;
		diff  = 5'(key_s1) + 5'(OCTAVE) - 5'(tonic);
		rel   = (diff >= 5'(OCTAVE)) ? 4'(diff - 5'(OCTAVE)) : diff[3:0];
		// nearest scale step at or below rel
		deg = 3'd0;
		for (int i = 1; i < 7; i++) begin
			if (MODE_TAB[mode][i] <= rel) begin
				deg = 3'(i);
			end
		end
	end

	always_comb begin
		entry           = '0;
		entry.key_valid = kv;
		entry.mask[SLOT_ROOT] = 1'b1;
		if (cfg.triad_form == TRIAD_DIATONIC) begin
			entry.notes[SLOT_THIRD] = step_up(mode, deg, STEPS_THIRD);
			entry.notes[SLOT_FIFTH] = step_up(mode, deg, STEPS_FIFTH);
		end else begin
			entry.notes[SLOT_THIRD] = 5'(TRIAD_TAB[cfg.triad_form][0]);
			entry.notes[SLOT_FIFTH] = 5'(TRIAD_TAB[cfg.triad_form][1]);
		end
		entry.mask[SLOT_THIRD] = cfg.triad_form != TRIAD_ROOT_ONLY;
		entry.mask[SLOT_FIFTH] = cfg.triad_form != TRIAD_ROOT_ONLY;
		unique case (sev_form_t'(cfg.seventh_form))
			SEV_SIXTH: entry.notes[SLOT_SEVENTH] = SIXTH_SEMIS;
			SEV_MIN7:  entry.notes[SLOT_SEVENTH] = MIN7_SEMIS;
			SEV_MAJ7:  entry.notes[SLOT_SEVENTH] = MAJ7_SEMIS;
			default:   entry.notes[SLOT_SEVENTH] = step_up(mode, deg, STEPS_SEVENTH);
		endcase
		entry.mask[SLOT_SEVENTH] = (cfg.seventh_form != SEV_NONE) || cfg.add_seventh;
		entry.notes[SLOT_NINTH]  = step_up(mode, deg, STEPS_NINTH);
		entry.notes[SLOT_ELEVEN] = step_up(mode, deg, STEPS_ELEVEN);
		entry.notes[SLOT_THIRTN] = step_up(mode, deg, STEPS_THIRTN);
		entry.mask[SLOT_NINTH]   = cfg.add_ninth;
		entry.mask[SLOT_ELEVEN]  = cfg.add_eleventh;
		entry.mask[SLOT_THIRTN]  = cfg.add_thirteenth;
		// bad key: a lone silent root
		if (!kv) begin
			entry.notes = '0;
			entry.mask  = SLOTS'(1);
		end
	end

endmodule

// ===== rtl/dcib_queue.sv =====
// short queue of classified chord entries between front and back
// depends on dcib_pkg
module dcib_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             q_ready,
	input  dcib_pkg::entry_t wr_entry,
	input  logic             pop,
	output logic             q_valid,
	output dcib_pkg::entry_t rd_entry
);
	import dcib_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_ready  = count_q != QCNT_W'(QDEPTH);
	assign q_valid  = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== rtl/dcib_back.sv =====
// back: walks the sounding notes of an entry, one result beat per cycle while the result side is ready
// depends on dcib_pkg and the assertion macro header
`include "diatonic_chord_interval_builder_macros.svh"
module dcib_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  dcib_pkg::entry_t              rd_entry,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dcib_pkg::NOTE_W-1:0]   interval_semis,
	output logic [dcib_pkg::IDX_W-1:0]    note_index,
	output logic                          last_note,
	output logic                          key_valid
);
	import dcib_pkg::*;

	logic [SLOTS-1:0][NOTE_W-1:0] notes_q;
	logic [SLOTS-1:0]             remain_q;
	logic                         kv_q;
	logic [IDX_W-1:0]             idx_q;

	logic                out_valid_q;
	logic [NOTE_W-1:0]   interval_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                last_q;
	logic                out_kv_q;

	logic              active;
	logic              out_free;
	logic              emit;
	logic              emit_last;
	logic [2:0]        sel;
	logic [SLOTS-1:0]  rest;

	always_comb begin
		sel = 3'd0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (remain_q[i]) begin
				sel = 3'(i);
			end
		end
		rest      = remain_q & ~(SLOTS'(1) << sel);
		active    = remain_q != '0;
		out_free  = !out_valid_q || out_ready;
		emit      = active && out_free;
		emit_last = (rest == '0) || (idx_q == MAX_IDX);
		pop       = q_valid && (!active || (emit && emit_last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				remain_q <= rd_entry.mask;
				idx_q    <= '0;
			end else if (emit) begin
				remain_q <= emit_last ? '0 : rest;
				idx_q    <= idx_q + IDX_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			notes_q <= rd_entry.notes;
			kv_q    <= rd_entry.key_valid;
		end
		if (emit) begin
			interval_q <= notes_q[sel];
			out_idx_q  <= idx_q;
			last_q     <= emit_last;
			out_kv_q   <= kv_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign interval_semis = interval_q;
	assign note_index     = out_idx_q;
	assign last_note      = last_q;
	assign key_valid      = out_kv_q;

	// notes of one chord leave back to back with rising index
	`DCIB_ASSERT_NXT(a_idx_step, clk, arst_n, out_valid_q && out_ready && !last_q, out_valid_q && (out_idx_q == $past(out_idx_q) + IDX_W'(1)))
	// a bad key gives a single silent root
	`DCIB_ASSERT_IMP(a_bad_key, clk, arst_n, out_valid_q && !out_kv_q, last_q && (out_idx_q == '0) && (interval_q == '0))
	// no new entry is taken while the current chord has notes left to send
	`DCIB_ASSERT_IMP(a_pop_safe, clk, arst_n, pop && active, emit && emit_last)

endmodule

// ===== rtl/diatonic_chord_interval_builder.sv =====
// top level of the diatonic chord interval builder: config registers, front, queue, back
// depends on dcib_pkg, dcib_front, dcib_queue and dcib_back
//
// channel   direction  handshake             payload
// key       in         in_valid/in_ready     key_class
// result    out        out_valid/out_ready   interval_semis, note_index, last_note, key_valid
// config    in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a key beat is taken every cycle while the entry queue has room; the front registers it
// and classifies it (scale degree and all candidate intervals from constant tables)
// the back sends one result beat per cycle while the result side is ready, one beat per
// sounding note of a key; that back walk sets the sustained rate
// a stall on the result side fills the two-entry queue before the key side stalls
// reset clears all control state and the config registers to zero; no clearing pass
module diatonic_chord_interval_builder (
	input  logic                        clk,
	input  logic                        arst_n,
	// config write channel, always ready
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [3:0]                  cfg_data,
	// key channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  key_class,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dcib_pkg::NOTE_W-1:0] interval_semis,
	output logic [dcib_pkg::IDX_W-1:0]  note_index,
	output logic                        last_note,
	output logic                        key_valid
);
	import dcib_pkg::*;

	cfg_t   cfg_q;
	entry_t wr_entry;
	entry_t rd_entry;
	logic   push;
	logic   pop;
	logic   q_ready;
	logic   q_valid;

	assign cfg_ready = 1'b1;

	// register file; fields keep only their own width of the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCALE_MODE:     cfg_q.scale_mode     <= cfg_data[2:0];
				CFG_TONIC_CLASS:    cfg_q.tonic_class    <= cfg_data;
				CFG_TRIAD_FORM:     cfg_q.triad_form     <= cfg_data[2:0];
				CFG_SEVENTH_FORM:   cfg_q.seventh_form   <= cfg_data[1:0];
				CFG_ADD_SEVENTH:    cfg_q.add_seventh    <= cfg_data[0];
				CFG_ADD_NINTH:      cfg_q.add_ninth      <= cfg_data[0];
				CFG_ADD_ELEVENTH:   cfg_q.add_eleventh   <= cfg_data[0];
				CFG_ADD_THIRTEENTH: cfg_q.add_thirteenth <= cfg_data[0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// front: key register and classification
	dcib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_class (key_class),
		.push      (push),
		.q_ready   (q_ready),
		.entry     (wr_entry)
	);

	// decouples classification from note delivery
	dcib_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_ready  (q_ready),
		.wr_entry (wr_entry),
		.pop      (pop),
		.q_valid  (q_valid),
		.rd_entry (rd_entry)
	);

	// back: one chord note per result beat through an output register
	dcib_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.rd_entry       (rd_entry),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.interval_semis (interval_semis),
		.note_index     (note_index),
		.last_note      (last_note),
		.key_valid      (key_valid)
	);

endmodule

// ===== sim/chord_note_checker.sv =====
// checker for the diatonic chord interval builder: keeps its own copy of the registers,
// predicts the chord notes of every accepted key and compares each result beat in order
// depends on dcib_pkg for the register index, triad and seventh form codes and the note cap
module chord_note_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [3:0] key_class,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [4:0] interval_semis,
	input  logic [2:0] note_index,
	input  logic       last_note,
	input  logic       key_valid,
	output int         fail_count,
	output logic       drained
);
	timeunit 1ns;
	timeprecision 1ps;
	import dcib_pkg::*;

	localparam int NOTE_CAP = MAX_NOTES;
	localparam int PITCHES  = 12;
	localparam int DEGREES  = 7;

	localparam logic [4:0] ADDED_SIXTH = 5'd9;
	localparam logic [4:0] ADDED_MIN7  = 5'd10;
	localparam logic [4:0] ADDED_MAJ7  = 5'd11;

	localparam logic [3:0] MODE_STEPS [0:6][0:6] = '{
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10}
	};

	// third and fifth of the fixed triad forms, entry 0 unused
	localparam logic [4:0] FIXED_TRIAD [0:6][0:1] = '{
		'{5'd0, 5'd0}, '{5'd4, 5'd7}, '{5'd3, 5'd7}, '{5'd3, 5'd6},
		'{5'd4, 5'd8}, '{5'd2, 5'd7}, '{5'd5, 5'd7}
	};

	typedef struct packed {
		logic [4:0] semis;
		logic [2:0] idx;
		logic       last;
		logic       valid_key;
	} chord_note_t;

	chord_note_t pending_notes [$];
	chord_note_t want_note;
	chord_note_t seen_note;

	logic [2:0] reg_mode;
	logic [3:0] reg_tonic;
	logic [2:0] reg_triad;
	logic [1:0] reg_seventh;
	logic       reg_add7;
	logic       reg_add9;
	logic       reg_add11;
	logic       reg_add13;

	// semitones from scale degree deg up by steps scale steps
	function automatic logic [4:0] degree_span(input int mode_sel, input int deg, input int steps);
		int t;
		t = deg + steps;
		return 5'(int'(MODE_STEPS[mode_sel][t % DEGREES]) + PITCHES * (t / DEGREES)
			- int'(MODE_STEPS[mode_sel][deg]));
	endfunction

	// queue the notes that one accepted key should produce
	function automatic void build_chord(input logic [3:0] key);
		int mode_sel;
		int rel;
		int deg;
		int cnt;
		int lim;
		logic [4:0] tones [0:7];
		chord_note_t n;
		if (key >= PITCHES) begin
			n = '{semis: 5'd0, idx: 3'd0, last: 1'b1, valid_key: 1'b0};
			pending_notes.push_back(n);
			return;
		end
		mode_sel = int'(reg_mode) % DEGREES;
		rel = (int'(key) + PITCHES - int'(reg_tonic) % PITCHES) % PITCHES;
		// highest scale step not above the key
		deg = 0;
		for (int i = 1; i < DEGREES; i++)
			if (int'(MODE_STEPS[mode_sel][i]) <= rel)
				deg = i;
		tones[0] = 5'd0;
		cnt = 1;
		if (reg_triad == TRIAD_DIATONIC) begin
			tones[cnt] = degree_span(mode_sel, deg, 2);
			tones[cnt + 1] = degree_span(mode_sel, deg, 4);
			cnt += 2;
		end else if (reg_triad != TRIAD_ROOT_ONLY) begin
			tones[cnt] = FIXED_TRIAD[reg_triad][0];
			tones[cnt + 1] = FIXED_TRIAD[reg_triad][1];
			cnt += 2;
		end
		case (reg_seventh)
			SEV_SIXTH: begin
				tones[cnt] = ADDED_SIXTH;
				cnt++;
			end
			SEV_MIN7: begin
				tones[cnt] = ADDED_MIN7;
				cnt++;
			end
			SEV_MAJ7: begin
				tones[cnt] = ADDED_MAJ7;
				cnt++;
			end
			default: begin
				if (reg_add7) begin
					tones[cnt] = degree_span(mode_sel, deg, 6);
					cnt++;
				end
			end
		endcase
		if (reg_add9) begin
			tones[cnt] = degree_span(mode_sel, deg, 8);
			cnt++;
		end
		if (reg_add11) begin
			tones[cnt] = degree_span(mode_sel, deg, 10);
			cnt++;
		end
		if (reg_add13) begin
			tones[cnt] = degree_span(mode_sel, deg, 12);
			cnt++;
		end
		lim = (cnt < NOTE_CAP) ? cnt : NOTE_CAP;
		for (int k = 0; k < lim; k++) begin
			n = '{semis: tones[k], idx: 3'(k), last: (k + 1 == lim), valid_key: 1'b1};
			pending_notes.push_back(n);
		end
	endfunction

	function automatic void note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%t mismatch (%s): ", $realtime, what,
				"expected semis=%0d idx=%0d last=%0b valid=%0b, ",
				want_note.semis, want_note.idx, want_note.last, want_note.valid_key,
				"got semis=%0d idx=%0d last=%0b valid=%0b",
				seen_note.semis, seen_note.idx, seen_note.last, seen_note.valid_key);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_mode    = '0;
			reg_tonic   = '0;
			reg_triad   = '0;
			reg_seventh = '0;
			reg_add7    = 1'b0;
			reg_add9    = 1'b0;
			reg_add11   = 1'b0;
			reg_add13   = 1'b0;
			pending_notes.delete();
			fail_count  = 0;
			drained    <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCALE_MODE:     reg_mode    = cfg_data[2:0];
					CFG_TONIC_CLASS:    reg_tonic   = cfg_data;
					CFG_TRIAD_FORM:     reg_triad   = cfg_data[2:0];
					CFG_SEVENTH_FORM:   reg_seventh = cfg_data[1:0];
					CFG_ADD_SEVENTH:    reg_add7    = cfg_data[0];
					CFG_ADD_NINTH:      reg_add9    = cfg_data[0];
					CFG_ADD_ELEVENTH:   reg_add11   = cfg_data[0];
					CFG_ADD_THIRTEENTH: reg_add13   = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen_note = '{semis: interval_semis, idx: note_index, last: last_note,
					valid_key: key_valid};
				if (pending_notes.size() == 0) begin
					want_note = 'x;
					note_failure("no beat expected");
				end else begin
					want_note = pending_notes.pop_front();
					if (seen_note.semis !== want_note.semis)
						note_failure("interval_semis");
					else if (seen_note.idx !== want_note.idx)
						note_failure("note_index");
					else if (seen_note.last !== want_note.last)
						note_failure("last_note");
					else if (seen_note.valid_key !== want_note.valid_key)
						note_failure("key_valid");
				end
			end
			if (in_valid && in_ready)
				build_chord(key_class);
			drained <= (pending_notes.size() == 0);
		end
	end

endmodule

// ===== sim/diatonic_chord_interval_builder_tb.sv =====
// testbench top of the diatonic chord interval builder: clock, reset, config phases,
// key stimulus with bursts and gaps, a stalling result side and the final verdict
// depends on dcib_pkg, the block itself and chord_note_checker
module diatonic_chord_interval_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dcib_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int KEYS_PER_RAND = 20;
	localparam int RAND_PHASES   = 13;

	// fixed triad forms and modes used by name in the directed part
	localparam logic [3:0] TRI_MAJOR     = 4'd1;
	localparam logic [3:0] TRI_MINOR     = 4'd2;
	localparam logic [3:0] TRI_DIMINISH  = 4'd3;
	localparam logic [3:0] TRI_AUGMENT   = 4'd4;
	localparam logic [3:0] TRI_SUS2      = 4'd5;
	localparam logic [3:0] TRI_SUS4      = 4'd6;
	localparam logic [3:0] MODE_IONIAN   = 4'd0;
	localparam logic [3:0] MODE_LYDIAN   = 4'd3;
	localparam logic [3:0] MODE_LOCRIAN  = 4'd6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] key_class = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [4:0] interval_semis;
	logic [2:0] note_index;
	logic       last_note;
	logic       key_valid;

	int   fail_count;
	logic drained;
	int   cycle_count = 0;
	int   burst_left = 0;
	int   stall_cnt = 0;
	int   stall_mode = 0;

	always #5 clk = ~clk;

	diatonic_chord_interval_builder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_class      (key_class),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.interval_semis (interval_semis),
		.note_index     (note_index),
		.last_note      (last_note),
		.key_valid      (key_valid)
	);

	chord_note_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_class      (key_class),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.interval_semis (interval_semis),
		.note_index     (note_index),
		.last_note      (last_note),
		.key_valid      (key_valid),
		.fail_count     (fail_count),
		.drained        (drained)
	);

	// watchdog: a hung handshake or a missing beat ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("diatonic_chord_interval_builder test failed");
			$finish;
		end
	end

	// result side stalls: a new pattern is picked at intervals of the stall counter, either always
	// ready, coin flips, ready only where the stall counter is a multiple of four, or mostly ready
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 64 == 63)
			stall_mode <= int'($urandom_range(0, 3));
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_cnt % 4 == 0);
			default: out_ready <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// one register beat; cfg_valid stays up so back-to-back writes need no re-raise
	task automatic cfg_write(input cfg_idx_t idx, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// write all eight registers, only ever called with the block drained
	task automatic load_settings(input logic [3:0] mode, input logic [3:0] tonic,
			input logic [3:0] triad, input logic [3:0] sev, input logic [3:0] a7,
			input logic [3:0] a9, input logic [3:0] a11, input logic [3:0] a13);
		cfg_write(CFG_SCALE_MODE, mode);
		cfg_write(CFG_TONIC_CLASS, tonic);
		cfg_write(CFG_TRIAD_FORM, triad);
		cfg_write(CFG_SEVENTH_FORM, sev);
		cfg_write(CFG_ADD_SEVENTH, a7);
		cfg_write(CFG_ADD_NINTH, a9);
		cfg_write(CFG_ADD_ELEVENTH, a11);
		cfg_write(CFG_ADD_THIRTEENTH, a13);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one key beat; bursts of random length, random gaps between them,
	// and a gap of zero keeps in_valid up across bursts
	task automatic press_key(input logic [3:0] k);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid  <= 1'b1;
		key_class <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	// drop in_valid and let every predicted note arrive, plus a short margin
	// for the block's pipeline before the next register write
	task automatic drain_block();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (!drained)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [3:0] random_key();
		// mostly playable pitch classes, now and then one of the invalid codes
		if ($urandom_range(0, 7) == 0)
			return 4'($urandom_range(12, 15));
		return 4'($urandom_range(0, 11));
	endfunction

	// register value: mostly in the documented range, sometimes any 4 bits
	function automatic logic [3:0] random_field(input int hi);
		if ($urandom_range(0, 3) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(0, hi));
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ionian on c, diatonic triad; extreme and invalid keys
		press_key(4'd0);
		press_key(4'd11);
		press_key(4'd12);
		press_key(4'd15);
		drain_block();

		// locrian on the top tonic, full stack of diatonic extensions
		load_settings(MODE_LOCRIAN, 4'd11, 4'(TRIAD_DIATONIC), 4'(SEV_NONE),
			4'd1, 4'd1, 4'd1, 4'd1);
		press_key(4'd0);
		press_key(4'd5);
		press_key(4'd11);
		drain_block();

		// unused mode value wraps, tonic above 11 wraps, unused triad drops third and fifth
		load_settings(4'(MODE_WRAP), 4'd15, 4'(TRIAD_ROOT_ONLY), 4'(SEV_SIXTH),
			4'd0, 4'd1, 4'd0, 4'd1);
		press_key(4'd3);
		press_key(4'd14);
		press_key(4'd9);
		drain_block();

		// fixed triads, with and without the fixed sevenths; the diatonic seventh flag is ignored under a fixed seventh
		load_settings(MODE_LYDIAN, 4'd12, TRI_AUGMENT, 4'(SEV_MAJ7), 4'd1, 4'd0, 4'd1, 4'd0);
		press_key(4'd7);
		press_key(4'd10);
		drain_block();

		load_settings(MODE_IONIAN, 4'd5, TRI_SUS4, 4'(SEV_MIN7), 4'd0, 4'd0, 4'd0, 4'd0);
		press_key(4'd1);
		press_key(4'd13);
		drain_block();

		load_settings(MODE_IONIAN, 4'd2, TRI_MAJOR, 4'(SEV_NONE), 4'd0, 4'd1, 4'd1, 4'd0);
		press_key(4'd4);
		drain_block();

		load_settings(MODE_LYDIAN, 4'd7, TRI_MINOR, 4'(SEV_NONE), 4'd1, 4'd0, 4'd0, 4'd1);
		press_key(4'd6);
		drain_block();

		load_settings(MODE_LOCRIAN, 4'd0, TRI_DIMINISH, 4'(SEV_SIXTH),
			4'd0, 4'd1, 4'd0, 4'd0);
		press_key(4'd8);
		drain_block();

		load_settings(MODE_IONIAN, 4'd9, TRI_SUS2, 4'(SEV_MIN7), 4'd0, 4'd0, 4'd1, 4'd1);
		press_key(4'd2);
		drain_block();

		// random phases: first the in-range maxima, then all ones, then all zeros,
		// after that random settings with random keys
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: load_settings(MODE_LOCRIAN, 4'd11, TRI_SUS4, 4'(SEV_MAJ7),
					4'd1, 4'd1, 4'd1, 4'd1);
				1: load_settings(4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf);
				2: load_settings(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
				default: load_settings(random_field(6), random_field(11), random_field(6),
					random_field(3), random_field(1), random_field(1),
					random_field(1), random_field(1));
			endcase
			for (int i = 0; i < KEYS_PER_RAND; i++)
				press_key(random_key());
			drain_block();
		end

		if (fail_count == 0)
			$display("diatonic_chord_interval_builder test passed");
		else
			$display("diatonic_chord_interval_builder test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dcib_pkg.sv
rtl/dcib_front.sv
rtl/dcib_queue.sv
rtl/dcib_back.sv
rtl/diatonic_chord_interval_builder.sv
sim/chord_note_checker.sv
sim/diatonic_chord_interval_builder_tb.sv
